/* rtl/pbr_pkg.sv */
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared types and constants of the proximity blink-rate LED block.
// ----------------------------------------------------------------------------
`default_nettype none

package pbr_pkg;

    localparam int CM_W       = 11;
    localparam int DIST_W     = 10;
    localparam int FAST_W     = 10;
    localparam int SLOW_W     = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int PROD_W     = DIST_W + SLOW_W;
    localparam int PER_W      = SLOW_W + 1;
    localparam int HALF_W     = PER_W - 1;
    localparam int DIV_STEPS  = PROD_W;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_PANIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW  = 2'd3;

    localparam logic [DIST_W-1:0] PANIC_RST = 10'd10;
    localparam logic [DIST_W-1:0] BLINK_RST = 10'd100;
    localparam logic [FAST_W-1:0] FAST_RST  = 10'd80;
    localparam logic [SLOW_W-1:0] SLOW_RST  = 12'd500;

    typedef struct packed {
        logic [DIST_W-1:0] panic;
        logic [DIST_W-1:0] blink;
        logic [FAST_W-1:0] fast;
        logic [SLOW_W-1:0] slow;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic decide;
        logic div_step;
        logic adjust;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic needs_div;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* rtl/pbr_ctrl.sv */
// ----------------------------------------------------------------------------
// pbr_ctrl
// Sequencer: takes a tick beat, steps the datapath through the period
// calculation and commits the LED state when the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pbr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  pbr_pkg::t_status       i_status,
    output logic                   o_ready,
    output pbr_pkg::t_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_ADJUST,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_status.needs_div ? S_DIV : S_FINISH;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_ADJUST;
                end
            end
            S_ADJUST: begin
                o_cmd.adjust = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.commit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* rtl/pbr_dpath.sv */
// ----------------------------------------------------------------------------
// pbr_dpath
// Datapath: tick capture, period interpolation with a restoring divider,
// elapsed counter, blink phase and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbr_dpath #(
    parameter int ELAPSED_WIDTH = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  pbr_pkg::t_cmd                     i_cmd,
    input  pbr_pkg::t_cfg                     i_cfg,
    input  wire logic                         i_active,
    input  wire logic [pbr_pkg::CM_W-1:0]     i_distance_cm,
    input  wire logic                         i_ready,
    output pbr_pkg::t_status                  o_status,
    output logic                              o_valid,
    output logic                              o_led_on
);

    logic                          r_active;
    logic [pbr_pkg::CM_W-1:0]      r_cm;
    logic [pbr_pkg::PROD_W-1:0]    r_quo;
    logic [pbr_pkg::DIST_W-1:0]    r_rem;
    logic [pbr_pkg::CNT_W-1:0]     r_cnt;
    logic [pbr_pkg::HALF_W-1:0]    r_half;
    logic [ELAPSED_WIDTH-1:0]      r_elapsed;
    logic                          r_phase;

    logic                          far;
    logic                          near;
    logic [pbr_pkg::DIST_W-1:0]    off;
    logic [pbr_pkg::DIST_W-1:0]    span;
    logic                          slow_ge;
    logic [pbr_pkg::SLOW_W-1:0]    fast_ext;
    logic [pbr_pkg::SLOW_W-1:0]    diff;
    logic [pbr_pkg::PROD_W-1:0]    prod;
    logic [pbr_pkg::DIST_W:0]      trial;
    logic [pbr_pkg::DIST_W:0]      trial_sub;
    logic                          trial_ge;
    logic [pbr_pkg::PER_W-1:0]     period;
    logic [ELAPSED_WIDTH-1:0]      elapsed_inc;
    logic [ELAPSED_WIDTH-1:0]      n_elapsed;
    logic                          n_phase;

    assign far  = !r_cm[pbr_pkg::CM_W-1] && (r_cm[pbr_pkg::DIST_W-1:0] > i_cfg.blink);
    assign near = r_cm[pbr_pkg::CM_W-1] || (r_cm[pbr_pkg::DIST_W-1:0] <= i_cfg.panic)
                  || (i_cfg.blink <= i_cfg.panic);

    assign off      = r_cm[pbr_pkg::DIST_W-1:0] - i_cfg.panic;
    assign span     = i_cfg.blink - i_cfg.panic;
    assign fast_ext = pbr_pkg::SLOW_W'(i_cfg.fast);
    assign slow_ge  = (i_cfg.slow >= fast_ext);
    assign diff     = slow_ge ? (i_cfg.slow - fast_ext) : (fast_ext - i_cfg.slow);
    assign prod     = pbr_pkg::PROD_W'(off) * pbr_pkg::PROD_W'(diff);

    // one quotient bit per step
    assign trial     = {r_rem, r_quo[pbr_pkg::PROD_W-1]};
    assign trial_ge  = (trial >= {1'b0, span});
    assign trial_sub = trial - {1'b0, span};

    assign period = slow_ge
        ? (pbr_pkg::PER_W'(fast_ext) + pbr_pkg::PER_W'(r_quo[pbr_pkg::SLOW_W-1:0]))
        : (pbr_pkg::PER_W'(fast_ext) - pbr_pkg::PER_W'(r_quo[pbr_pkg::SLOW_W-1:0]));

    assign elapsed_inc = (r_elapsed == '1) ? r_elapsed : (r_elapsed + 1'b1);

    always_comb begin
        n_elapsed = elapsed_inc;
        n_phase   = r_phase;
        priority if (!r_active) begin
            n_phase = 1'b0;
        end else if (far) begin
            n_phase = 1'b1;
        end else if (elapsed_inc >= ELAPSED_WIDTH'(r_half)) begin
            n_elapsed = '0;
            n_phase   = !r_phase;
        end
    end

    assign o_status.needs_div = r_active && !far && !near;
    assign o_status.div_last  = (r_cnt == pbr_pkg::CNT_W'(1));
    assign o_status.out_free  = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_active <= i_active;
            r_cm     <= i_distance_cm;
        end
        if (i_cmd.decide) begin
            r_half <= pbr_pkg::HALF_W'(i_cfg.fast[pbr_pkg::FAST_W-1:1]);
            r_quo  <= prod;
            r_rem  <= '0;
            r_cnt  <= pbr_pkg::CNT_W'(pbr_pkg::DIV_STEPS);
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[pbr_pkg::PROD_W-2:0], trial_ge};
            r_rem <= trial_ge ? trial_sub[pbr_pkg::DIST_W-1:0] : trial[pbr_pkg::DIST_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.adjust) begin
            r_half <= period[pbr_pkg::PER_W-1:1];
        end
        if (i_cmd.commit) begin
            o_led_on <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_phase   <= 1'b1;
            o_valid   <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_elapsed <= n_elapsed;
                r_phase   <= n_phase;
                o_valid   <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/proximity_blink_rate_led.sv */
// Sequence: accept, decide and finish when inactive, steady or at the fast rate;
// accept, decide, 22 restoring divider steps, adjust and finish when interpolated.
// A new tick is accepted only after the last result commits to a free output.
// Reset (synchronous, active low): registers to defaults, counter 0, phase lit.
// ----------------------------------------------------------------------------
// proximity_blink_rate_led
// Parking sensor style LED: steady beyond the blink distance, blinking with
// a distance dependent period below it, dark while inactive.
// ----------------------------------------------------------------------------
`default_nettype none

module proximity_blink_rate_led #(
    parameter int ELAPSED_WIDTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [pbr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [pbr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_active,
    input  wire logic signed [pbr_pkg::CM_W-1:0]    i_distance_cm,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_led_on
);

    pbr_pkg::t_cfg    r_cfg;
    pbr_pkg::t_cmd    cmd;
    pbr_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.panic <= pbr_pkg::PANIC_RST;
            r_cfg.blink <= pbr_pkg::BLINK_RST;
            r_cfg.fast  <= pbr_pkg::FAST_RST;
            r_cfg.slow  <= pbr_pkg::SLOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pbr_pkg::CFG_PANIC: r_cfg.panic <= i_cfg_data[pbr_pkg::DIST_W-1:0];
                pbr_pkg::CFG_BLINK: r_cfg.blink <= i_cfg_data[pbr_pkg::DIST_W-1:0];
                pbr_pkg::CFG_FAST:  r_cfg.fast  <= i_cfg_data[pbr_pkg::FAST_W-1:0];
                pbr_pkg::CFG_SLOW:  r_cfg.slow  <= i_cfg_data[pbr_pkg::SLOW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pbr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    pbr_dpath #(
        .ELAPSED_WIDTH (ELAPSED_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (r_cfg),
        .i_active      (i_active),
        .i_distance_cm (i_distance_cm),
        .i_ready       (i_ready),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_led_on      (o_led_on)
    );

    // a result never overwrites one still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!o_valid || i_ready))
        else $error("commit while output register held");

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_valid)
        else $error("committed beat not presented");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after accept");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_step |-> (!o_ready && !cmd.commit))
        else $error("divider stepping outside busy window");

endmodule

`default_nettype wire

/* bench/proximity_blink_rate_led_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_blink_rate_led_tb
// Self-checking bench for the blink-rate LED. A short table of directed ticks
// runs first. Randomized phases follow, each with its own register setting,
// sender and receiver idling and runs of distances. Every output beat is checked
// against a fixed table value or an in-bench model of tick count and blink phase.
// ----------------------------------------------------------------------------
module proximity_blink_rate_led_tb;

    localparam int ELAPSED_W       = 16;
    localparam int PHASES          = 10;
    localparam int TICKS_PER_PHASE = 124;
    localparam int PRESSURE_PHASE  = 5;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct {
        logic                            active;
        logic signed [pbr_pkg::CM_W-1:0] cm;
        bit                              fixed;
        logic                            led;
    } t_tick_row;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [pbr_pkg::CFG_IDX_W-1:0]   i_cfg_idx     = pbr_pkg::CFG_PANIC;
    logic [pbr_pkg::CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                            i_valid       = 1'b0;
    logic                            i_active      = 1'b0;
    logic signed [pbr_pkg::CM_W-1:0] i_distance_cm = '0;
    logic                            i_ready       = 1'b0;
    logic                            o_ready;
    logic                            o_valid;
    logic                            o_led_on;

    // in-bench copy of the registers and state
    pbr_pkg::t_cfg        led_cfg      = '{pbr_pkg::PANIC_RST, pbr_pkg::BLINK_RST,
                                           pbr_pkg::FAST_RST, pbr_pkg::SLOW_RST};
    logic [ELAPSED_W-1:0] tick_count   = '0;
    logic                 blink_phase  = 1'b1;

    logic led_expect_q [$];
    int   mismatch_count = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_requested = 0;
    int   hold_served    = 0;
    int   hold_left      = 0;

    // directed ticks, reset register values
    t_tick_row tick_rows [16] = '{
        '{1'b0, 11'sd0,    1'b1, 1'b0},
        '{1'b1, 11'sd1023, 1'b1, 1'b1},
        '{1'b1, 11'sd101,  1'b1, 1'b1},
        '{1'b1, 11'sd100,  1'b0, 1'b0},
        '{1'b1, 11'sd11,   1'b0, 1'b0},
        '{1'b1, 11'sd10,   1'b0, 1'b0},
        '{1'b1, 11'sd0,    1'b0, 1'b0},
        '{1'b1, 11'h7FF,   1'b0, 1'b0},
        '{1'b1, 11'h400,   1'b0, 1'b0},
        '{1'b0, 11'sd1023, 1'b1, 1'b0},
        '{1'b0, 11'h7FF,   1'b1, 1'b0},
        '{1'b1, 11'sd55,   1'b0, 1'b0},
        '{1'b1, 11'sd99,   1'b0, 1'b0},
        '{1'b1, 11'sd512,  1'b1, 1'b1},
        '{1'b1, 11'sd200,  1'b1, 1'b1},
        '{1'b1, 11'sd1,    1'b0, 1'b0}
    };

    proximity_blink_rate_led #(
        .ELAPSED_WIDTH(ELAPSED_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_active      (i_active),
        .i_distance_cm (i_distance_cm),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_led_on      (o_led_on)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic predict_led(input logic act,
                                         input logic signed [pbr_pkg::CM_W-1:0] cm);
        int          dist_cm;
        int unsigned panic_u, blink_u, fast_u, slow_u;
        int unsigned span, off, per, half;
        dist_cm = cm;
        panic_u = led_cfg.panic;
        blink_u = led_cfg.blink;
        fast_u  = led_cfg.fast;
        slow_u  = led_cfg.slow;
        if (tick_count != '1) begin
            tick_count = tick_count + 1'b1;
        end
        if (!act) begin
            blink_phase = 1'b0;
            return 1'b0;
        end
        if (dist_cm > int'(blink_u)) begin
            blink_phase = 1'b1;
            return 1'b1;
        end
        if (dist_cm <= int'(panic_u) || blink_u <= panic_u) begin
            half = fast_u / 2;
        end else begin
            span = blink_u - panic_u;
            off  = dist_cm - panic_u;
            if (slow_u >= fast_u) begin
                per = fast_u + (off * (slow_u - fast_u)) / span;
            end else begin
                per = fast_u - (off * (fast_u - slow_u)) / span;
            end
            half = per / 2;
        end
        if (tick_count >= half) begin
            tick_count  = '0;
            blink_phase = ~blink_phase;
        end
        return blink_phase;
    endfunction

    function automatic logic signed [pbr_pkg::CM_W-1:0] clip_cm(input int d);
        if (d < -1) begin
            d = -1;
        end else if (d > 1023) begin
            d = 1023;
        end
        return pbr_pkg::CM_W'(d);
    endfunction

    // one input beat; returns at the falling edge after the accept
    task automatic send_tick(input logic act, input logic signed [pbr_pkg::CM_W-1:0] cm,
                             input bit fixed, input logic led);
        logic led_exp;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_active      <= act;
        i_distance_cm <= cm;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        led_exp = predict_led(act, cm);
        led_expect_q.push_back(fixed ? led : led_exp);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (led_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(input int panic, input int blink, input int fast, input int slow);
        logic [pbr_pkg::CFG_IDX_W-1:0] idx_list [4];
        int                            val_list [4];
        idx_list = '{pbr_pkg::CFG_PANIC, pbr_pkg::CFG_BLINK, pbr_pkg::CFG_FAST,
                     pbr_pkg::CFG_SLOW};
        val_list = '{panic, blink, fast, slow};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_list[k];
            i_cfg_data <= pbr_pkg::CFG_DATA_W'(val_list[k]);
            @(negedge i_clk);
        end
        i_cfg_we      <= 1'b0;
        led_cfg.panic = pbr_pkg::DIST_W'(panic);
        led_cfg.blink = pbr_pkg::DIST_W'(blink);
        led_cfg.fast  = pbr_pkg::FAST_W'(fast);
        led_cfg.slow  = pbr_pkg::SLOW_W'(slow);
    endtask

    // receiver: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_served != hold_requested) begin
            hold_served <= hold_requested;
            hold_left   <= HOLD_OFF_CYCLES;
            i_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (led_expect_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: led beat with nothing expected, actual %0b", $time, o_led_on);
            end else if (o_led_on !== led_expect_q[0]) begin
                mismatch_count++;
                $display("%0t: led_on mismatch, expected %0b actual %0b",
                         $time, led_expect_q[0], o_led_on);
                void'(led_expect_q.pop_front());
            end else begin
                void'(led_expect_q.pop_front());
            end
        end
    end

    initial begin
        int   n, run_len, kind, cls, base, d;
        int   panic, blink, fast, slow;
        logic act;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (tick_rows[r]) begin
            send_tick(tick_rows[r].active, tick_rows[r].cm, tick_rows[r].fixed,
                      tick_rows[r].led);
        end
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    panic = 0;    blink = 1023; fast = 2;    slow = 4000;
                end
                1: begin
                    panic = 1022; blink = 1023; fast = 1000; slow = 2;
                end
                2: begin
                    panic = 50;   blink = 20;   fast = 6;    slow = 30;
                end
                3: begin
                    panic = 30;   blink = 30;   fast = 4;    slow = 2;
                end
                8: begin
                    panic = $urandom_range(0, 1022);
                    blink = $urandom_range(1, 1023);
                    fast  = $urandom_range(2, 1000);
                    slow  = $urandom_range(2, 4000);
                end
                default: begin
                    panic = $urandom_range(0, 120);
                    blink = $urandom_range(1, 200);
                    fast  = $urandom_range(2, 24);
                    slow  = $urandom_range(2, 80);
                end
            endcase
            set_config(panic, blink, fast, slow);

            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct  = 51;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 51;
                end
                default: begin
                    send_idle_pct  = 23;
                    recv_stall_pct <= 23;
                end
            endcase
            if (ph == PRESSURE_PHASE) begin
                send_idle_pct  = 0;
                hold_requested <= hold_requested + 1;
            end

            n = 0;
            while (n < TICKS_PER_PHASE) begin
                kind = $urandom_range(99);
                if (kind < 85) begin
                    // steady run of ticks around one distance
                    act = ($urandom_range(9) != 0);
                    cls = $urandom_range(5);
                    case (cls)
                        0: base = -1;
                        1: base = panic + $urandom_range(4) - 2;
                        2: base = (blink > panic) ? $urandom_range(panic, blink) : panic;
                        3: base = blink + $urandom_range(4) - 2;
                        4: base = $urandom_range(1023);
                        default: base = (blink < 1023) ? $urandom_range(blink + 1, 1023) : 1023;
                    endcase
                    run_len = $urandom_range(1, 40);
                    for (int t = 0; t < run_len && n < TICKS_PER_PHASE; t++) begin
                        d = base;
                        if (cls != 0 && $urandom_range(3) == 0) begin
                            d = base + $urandom_range(2) - 1;
                        end
                        send_tick(act, clip_cm(d), 1'b0, 1'b0);
                        n++;
                    end
                end else begin
                    run_len = $urandom_range(1, 6);
                    for (int t = 0; t < run_len && n < TICKS_PER_PHASE; t++) begin
                        d = $urandom_range(1024);
                        send_tick(1'($urandom_range(1)), clip_cm(d - 1), 1'b0, 1'b0);
                        n++;
                    end
                end
            end
            wait_idle();
        end

        if (mismatch_count == 0 && led_expect_q.size() == 0) begin
            $display("proximity_blink_rate_led_tb OK");
        end else begin
            $display("proximity_blink_rate_led_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("proximity_blink_rate_led_tb NOT OK");
        $finish;
    end

endmodule
